// ===== rtl/idu_pkg.sv =====
// Shared types and constants for the integer divide and modulo pipeline.
package idu_pkg;

   localparam int NumWidth        = 32;
   localparam int DenWidth        = 16;
   localparam int OpWidth         = 2;
   localparam int DefBitsPerStage = 4;

   // Mode codes; any code with the high bit set runs as unsigned 32/16.
   localparam logic [OpWidth-1:0] OP_UDIV16 = 2'd0;
   localparam logic [OpWidth-1:0] OP_SDIV16 = 2'd1;

   typedef struct packed {
      logic [DenWidth-1:0] rem;    // partial remainder
      logic [NumWidth-1:0] num;    // dividend bits shifting out, quotient bits shifting in
      logic [DenWidth-1:0] den;    // divisor magnitude
      logic                neg_q;  // negate quotient at the end
      logic                neg_r;  // negate remainder at the end
      logic                ok;     // divisor nonzero
   } pipe_type;

endpackage

// ===== rtl/idu_prep.sv =====
// Entry stage: decode the mode, take operand magnitudes and register the beat.
module idu_prep (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             in_valid,
   output logic                             in_ready,
   input  logic [idu_pkg::OpWidth-1:0]      operation,
   input  logic [idu_pkg::NumWidth-1:0]     numerator,
   input  logic [idu_pkg::DenWidth-1:0]     denominator,
   output logic                             out_valid,
   input  logic                             out_ready,
   output idu_pkg::pipe_type                out_data
);
   import idu_pkg::*;

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   always_comb begin
      data_in       = '0;
      data_in.ok    = |denominator;
      data_in.den   = denominator;
      case (operation)
         OP_UDIV16: begin
            data_in.num = {{(NumWidth-DenWidth){1'b0}}, numerator[DenWidth-1:0]};
         end
         OP_SDIV16: begin
            // magnitude of the most negative value stays 0x8000, read as unsigned
            data_in.num = {{(NumWidth-DenWidth){1'b0}},
                           numerator[DenWidth-1] ? DenWidth'(-numerator[DenWidth-1:0])
                                                 : numerator[DenWidth-1:0]};
            data_in.den = denominator[DenWidth-1] ? DenWidth'(-denominator) : denominator;
            data_in.neg_q = numerator[DenWidth-1] ^ denominator[DenWidth-1];
            data_in.neg_r = numerator[DenWidth-1];
         end
         default: begin
            data_in.num = numerator;
         end
      endcase
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/idu_div_stage.sv =====
// One pipeline stage of restoring division, retiring a few quotient bits.
module idu_div_stage #(
   parameter int BitsPerStage = idu_pkg::DefBitsPerStage
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              in_valid,
   output logic              in_ready,
   input  idu_pkg::pipe_type in_data,
   output logic              out_valid,
   input  logic              out_ready,
   output idu_pkg::pipe_type out_data
);
   import idu_pkg::*;

   logic     valid_ff;
   pipe_type data_ff;
   pipe_type data_in;

   always_comb begin
      logic [DenWidth:0] trial;
      data_in = in_data;
      trial   = '0;
      for (int i = 0; i < BitsPerStage; i++) begin
         trial        = {data_in.rem, data_in.num[NumWidth-1]};
         data_in.num  = {data_in.num[NumWidth-2:0], 1'b0};
         if (trial >= {1'b0, data_in.den}) begin
            data_in.rem    = DenWidth'(trial - {1'b0, data_in.den});
            data_in.num[0] = 1'b1;
         end else begin
            data_in.rem = trial[DenWidth-1:0];
         end
      end
   end

   assign in_ready  = !valid_ff || out_ready;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== rtl/idu_post.sv =====
// Exit stage: restore signs, apply the divide-by-zero result, hold the output beat.
module idu_post (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          in_ready,
   input  idu_pkg::pipe_type             in_data,
   output logic                          out_valid,
   input  logic                          out_ready,
   output logic [idu_pkg::DenWidth-1:0]  quotient,
   output logic [idu_pkg::DenWidth-1:0]  remainder,
   output logic                          valid_divide
);
   import idu_pkg::*;

   logic                valid_ff;
   logic [DenWidth-1:0] quot_ff;
   logic [DenWidth-1:0] quot_in;
   logic [DenWidth-1:0] rem_ff;
   logic [DenWidth-1:0] rem_in;
   logic                ok_ff;

   always_comb begin
      quot_in = in_data.num[DenWidth-1:0];
      rem_in  = in_data.rem;
      if (in_data.neg_q) begin
         quot_in = DenWidth'(-quot_in);
      end
      if (in_data.neg_r) begin
         rem_in = DenWidth'(-rem_in);
      end
      if (!in_data.ok) begin
         quot_in = '0;
         rem_in  = '0;
      end
   end

   assign in_ready     = !valid_ff || out_ready;
   assign out_valid    = valid_ff;
   assign quotient     = quot_ff;
   assign remainder    = rem_ff;
   assign valid_divide = ok_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready && in_valid) begin
         quot_ff <= quot_in;
         rem_ff  <= rem_in;
         ok_ff   <= in_data.ok;
      end
   end

endmodule

// ===== rtl/integer_divmod_unit.sv =====
// Pipelined divide and modulo unit: unsigned 16/16, signed 16/16, unsigned 32/16.
// Takes one beat per cycle while no stall backs up to the request side, and returns
// one result beat per request, in order. The pipeline has one entry stage that takes
// magnitudes, one restoring-division stage per BitsPerStage quotient bits (4 by
// default), and one exit stage that fixes signs. Every stage has its own valid bit
// and moves whenever the stage after it is empty or moving, so bubbles close up
// during a stall and nothing is dropped or repeated. Signed mode truncates toward
// zero with the remainder taking the dividend's sign; a zero divisor returns zero
// quotient and remainder with valid_divide low.
module integer_divmod_unit #(
   parameter int BitsPerStage = idu_pkg::DefBitsPerStage
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [47:0] req_tdata,   // [31:0] numerator, [47:32] denominator
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [15:0] quotient, [31:16] remainder
   output logic [0:0]  rsp_tuser    // [0] valid_divide
);
   import idu_pkg::*;

   localparam int NumStages = NumWidth / BitsPerStage;

   pipe_type link_data  [0:NumStages];
   logic     link_valid [0:NumStages];
   logic     link_ready [0:NumStages];

   idu_prep u_prep (
      .clock       (clock),
      .reset       (reset),
      .in_valid    (req_tvalid),
      .in_ready    (req_tready),
      .operation   (req_tuser),
      .numerator   (req_tdata[31:0]),
      .denominator (req_tdata[47:32]),
      .out_valid   (link_valid[0]),
      .out_ready   (link_ready[0]),
      .out_data    (link_data[0])
   );

   for (genvar s = 0; s < NumStages; s++) begin : g_stage
      idu_div_stage #(
         .BitsPerStage (BitsPerStage)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[s]),
         .in_ready  (link_ready[s]),
         .in_data   (link_data[s]),
         .out_valid (link_valid[s+1]),
         .out_ready (link_ready[s+1]),
         .out_data  (link_data[s+1])
      );
   end

   idu_post u_post (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (link_valid[NumStages]),
      .in_ready     (link_ready[NumStages]),
      .in_data      (link_data[NumStages]),
      .out_valid    (rsp_tvalid),
      .out_ready    (rsp_tready),
      .quotient     (rsp_tdata[15:0]),
      .remainder    (rsp_tdata[31:16]),
      .valid_divide (rsp_tuser[0])
   );

endmodule

// ===== tb/integer_divmod_unit_tb.sv =====
// Self-checking testbench for the integer divide and modulo pipeline.
`timescale 1ns / 1ps

module integer_divmod_unit_tb;
   import idu_pkg::*;

   // Codes the package leaves unnamed; the high bit selects unsigned 32/16.
   localparam logic [OpWidth-1:0] OP_UDIV32 = 2'd2;
   localparam logic [OpWidth-1:0] OP_SPARE  = 2'd3;

   localparam int LATENCY     = 32 / DefBitsPerStage + 2;
   localparam int LONG_HOLD   = 60;
   localparam int PHASE_ITEMS = 175;
   localparam int CYCLE_LIMIT = 300000;

   typedef enum int {
      READY_ALWAYS,
      READY_RANDOM,
      READY_PATTERN,
      READY_STARVED
   } ready_style_type;

   typedef struct packed {
      logic [OpWidth-1:0]  operation;
      logic [NumWidth-1:0] numerator;
      logic [DenWidth-1:0] denominator;
      logic [15:0]         quotient;
      logic [15:0]         remainder;
      logic                valid_divide;
   } divmod_result_type;

   class divmod_scoreboard;
      divmod_result_type expected_results[$];
      int                mismatches;

      function new();
         mismatches = 0;
      endfunction

      function divmod_result_type predict_divmod(logic [OpWidth-1:0] op,
                                                 logic [NumWidth-1:0] num,
                                                 logic [DenWidth-1:0] den);
         divmod_result_type res;
         int                dividend;
         int                divisor;
         logic [31:0]       wide_q;
         logic [31:0]       wide_r;
         res = '0;
         res.operation   = op;
         res.numerator   = num;
         res.denominator = den;
         if (den != 16'h0) begin
            res.valid_divide = 1'b1;
            if (op[1]) begin
               // Quotient keeps its low half only; remainder always fits.
               wide_q = num / {16'h0, den};
               wide_r = num % {16'h0, den};
               res.quotient  = wide_q[15:0];
               res.remainder = wide_r[15:0];
            end else if (op == OP_SDIV16) begin
               // 32-bit math keeps -32768 / -1 exact; the low half wraps to 0x8000.
               dividend = int'($signed(num[15:0]));
               divisor  = int'($signed(den));
               res.quotient  = 16'(dividend / divisor);
               res.remainder = 16'(dividend % divisor);
            end else begin
               res.quotient  = num[15:0] / den;
               res.remainder = num[15:0] % den;
            end
         end
         return res;
      endfunction

      function void note_request(logic [OpWidth-1:0] op, logic [NumWidth-1:0] num,
                                 logic [DenWidth-1:0] den);
         expected_results.push_back(predict_divmod(op, num, den));
      endfunction

      function void check_response(logic [15:0] quotient, logic [15:0] remainder,
                                   logic valid_divide);
         divmod_result_type want;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result beat: q %h r %h ok %b",
                        quotient, remainder, valid_divide);
            return;
         end
         want = expected_results.pop_front();
         if (quotient !== want.quotient || remainder !== want.remainder ||
             valid_divide !== want.valid_divide) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"mismatch op %0d num %h den %h: ",
                         "expected q %h r %h ok %b, got q %h r %h ok %b"},
                        want.operation, want.numerator, want.denominator,
                        want.quotient, want.remainder, want.valid_divide,
                        quotient, remainder, valid_divide);
         end
      endfunction

      function int pending();
         return expected_results.size();
      endfunction
   endclass

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [47:0] req_tdata  = '0;   // [31:0] numerator, [47:32] denominator
   logic [1:0]  req_tuser  = '0;   // [1:0] operation
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;         // [15:0] quotient, [31:16] remainder
   logic [0:0]  rsp_tuser;         // [0] valid_divide

   divmod_scoreboard divmod_sb;
   ready_style_type  ready_style      = READY_ALWAYS;
   bit               hold_off_request = 1'b0;
   int               cycle_count      = 0;

   integer_divmod_unit u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Result side: own stall pattern, plus a long hold-off on request.
   always begin : result_sink
      logic [7:0] ready_mask;
      ready_mask = 8'b1011_0010;
      @(posedge clock);
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off_request) begin
         hold_off_request = 1'b0;
         rsp_tready <= 1'b0;
         repeat (LONG_HOLD - 1) @(posedge clock);
      end else begin
         case (ready_style)
            READY_ALWAYS:  rsp_tready <= 1'b1;
            READY_RANDOM:  rsp_tready <= ($urandom_range(0, 3) != 0);
            READY_PATTERN: rsp_tready <= ready_mask[3'(cycle_count)];
            default:       rsp_tready <= ($urandom_range(0, 3) == 0);
         endcase
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         divmod_sb.check_response(rsp_tdata[15:0], rsp_tdata[31:16], rsp_tuser[0]);
   end

   task automatic send_item(input logic [OpWidth-1:0] op, input logic [NumWidth-1:0] num,
                            input logic [DenWidth-1:0] den);
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {den, num};
      do @(posedge clock); while (!req_tready);
      divmod_sb.note_request(op, num, den);
   endtask

   // Drop valid and scramble the bus while idle.
   task automatic idle_cycles(input int n);
      req_tvalid <= 1'b0;
      req_tdata  <= {16'($urandom), 32'($urandom)};
      req_tuser  <= 2'($urandom);
      repeat (n) @(posedge clock);
   endtask

   task automatic send_random_item();
      logic [OpWidth-1:0]  op;
      logic [NumWidth-1:0] num;
      logic [DenWidth-1:0] den;
      int                  pick;
      pick = $urandom_range(0, 15);
      if (pick < 5)       op = OP_UDIV16;
      else if (pick < 10) op = OP_SDIV16;
      else if (pick < 14) op = OP_UDIV32;
      else                op = OP_SPARE;
      case ($urandom_range(0, 15))
         0:       den = 16'h0000;
         1:       den = 16'hFFFF;
         2:       den = 16'h0001;
         3, 4:    den = 16'($urandom_range(1, 15));
         5:       den = 16'h8000;
         default: den = 16'($urandom);
      endcase
      case ($urandom_range(0, 7))
         0: num = {16'($urandom), 16'h8000};
         1: num = {16'($urandom), 16'($urandom_range(0, 31))};
         2: begin
            // Keep the 32/16 quotient in range when the divisor allows it.
            if (den != 16'h0)
               num = {16'h0, den} * {16'h0, 16'($urandom)} + 32'($urandom_range(0, den - 1));
            else
               num = $urandom;
         end
         default: num = $urandom;
      endcase
      send_item(op, num, den);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (divmod_sb.pending() != 0) @(posedge clock);
   endtask

   initial begin : main_sequence
      int burst_left;
      int phase;
      divmod_sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Field extremes, every mode and the named corner cases.
      send_item(OP_UDIV16, 32'h0000_0000, 16'h0001);
      send_item(OP_UDIV16, 32'h0000_FFFF, 16'h0001);
      send_item(OP_UDIV16, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_UDIV16, 32'hDEAD_1234, 16'h0007);
      send_item(OP_UDIV16, 32'h0000_1234, 16'h0000);
      send_item(OP_SDIV16, 32'h0000_8000, 16'hFFFF);
      send_item(OP_SDIV16, 32'h0000_FFF9, 16'h0002);
      send_item(OP_SDIV16, 32'h0000_0007, 16'hFFFE);
      send_item(OP_SDIV16, 32'hFFFF_FFF9, 16'hFFFE);
      send_item(OP_SDIV16, 32'h0000_7FFF, 16'h8000);
      send_item(OP_SDIV16, 32'h0000_8000, 16'h8000);
      send_item(OP_SDIV16, 32'h0000_8000, 16'h0001);
      send_item(OP_SDIV16, 32'h1234_7FFF, 16'h7FFF);
      send_item(OP_SDIV16, 32'h0000_8000, 16'h0000);
      send_item(OP_UDIV32, 32'hFFFF_FFFF, 16'h0001);
      send_item(OP_UDIV32, 32'hFFFF_FFFF, 16'hFFFF);
      send_item(OP_UDIV32, 32'h1234_5678, 16'h1234);
      send_item(OP_UDIV32, 32'h0001_0000, 16'h0001);
      send_item(OP_UDIV32, 32'h0000_0000, 16'h0000);
      send_item(OP_UDIV32, 32'hFFFF_FFFF, 16'h0000);
      send_item(OP_SPARE,  32'hFFFF_FFFF, 16'h0003);
      send_item(OP_SPARE,  32'h1234_5678, 16'h0000);
      send_item(OP_SPARE,  32'h0000_FFFF, 16'h8000);
      wait_drained();

      for (phase = 0; phase < 4; phase++) begin
         ready_style = ready_style_type'(phase);
         burst_left  = $urandom_range(1, 20);
         if (phase == 1) begin
            // Back the pipeline up against a stalled sink with no sender gaps for the first 80 items.
            hold_off_request = 1'b1;
            burst_left = 80;
         end
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            if (phase != 0 && burst_left == 0) begin
               idle_cycles(($urandom_range(0, 7) == 0) ? $urandom_range(8, 30)
                                                       : $urandom_range(1, 6));
               burst_left = $urandom_range(1, 20);
            end
            send_random_item();
            if (burst_left > 0) burst_left--;
         end
         wait_drained();
      end

      ready_style = READY_ALWAYS;
      repeat (4 * LATENCY) @(posedge clock);
      if (divmod_sb.mismatches == 0 && divmod_sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/idu_pkg.sv
rtl/idu_prep.sv
rtl/idu_div_stage.sv
rtl/idu_post.sv
rtl/integer_divmod_unit.sv
tb/integer_divmod_unit_tb.sv
